// ===== src/acm_pkg.sv =====
`default_nettype none
package acm_pkg;

	// default parameter values
	localparam int COORD_FRAC_BITS_DEF = 16;
	localparam int UV_FRAC_BITS_DEF = 16;
	localparam int ANGLE_STAGES_DEF = 16;

	// fixed datapath widths
	localparam int POS_W = 32;
	localparam int NORM_W = 16;
	localparam int DIFF_W = 33;
	localparam int XY_W = 58;
	localparam int Z_W = 35;
	localparam int VEC_SCALE = 20;
	localparam int ATAN_ENTRIES = 24;

	// configuration register indexes
	localparam logic [2:0] REG_MIN_X = 3'd0;
	localparam logic [2:0] REG_MAX_X = 3'd1;
	localparam logic [2:0] REG_MIN_Y = 3'd2;
	localparam logic [2:0] REG_MAX_Y = 3'd3;
	localparam logic [2:0] REG_MIN_Z = 3'd4;
	localparam logic [2:0] REG_MAX_Z = 3'd5;
	localparam logic [2:0] REG_DEPTH_Y = 3'd6;
	localparam logic [2:0] REG_CUBE = 3'd7;

	// region codes
	localparam logic [1:0] REGION_FRONT = 2'd0;
	localparam logic [1:0] REGION_BACK = 2'd1;
	localparam logic [1:0] REGION_SIDE = 2'd2;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};

	localparam logic signed [Z_W-1:0] TURN_QUARTER = 35'sd1073741824;
	localparam logic signed [Z_W-1:0] TURN_HALF = 35'sd2147483648;
	localparam logic signed [Z_W-1:0] TURN_FULL = 35'sd4294967296;

	// how an axis fraction is formed
	typedef enum logic [1:0] {
		FR_HALF,
		FR_ZERO,
		FR_ONE,
		FR_DIV
	} frac_mode_t;

	// per-request control carried down the chain
	typedef struct packed {
		logic cap;
		logic cube;
		logic upper;
		logic zero_vec;
		logic depth_y;
		logic nz_neg;
		logic [1:0] region;
		frac_mode_t mode_x;
		frac_mode_t mode_y;
		frac_mode_t mode_z;
	} ctrl_t;

endpackage
`default_nettype wire

// ===== src/acm_prep.sv =====
`default_nettype none
module acm_prep #(
	parameter int COORD_FRAC_BITS = acm_pkg::COORD_FRAC_BITS_DEF,
	parameter int UV_FRAC_BITS = acm_pkg::UV_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_valid,
	input wire logic signed [acm_pkg::POS_W-1:0] pos_x,
	input wire logic signed [acm_pkg::POS_W-1:0] pos_y,
	input wire logic signed [acm_pkg::POS_W-1:0] pos_z,
	input wire logic signed [acm_pkg::NORM_W-1:0] norm_x,
	input wire logic signed [acm_pkg::NORM_W-1:0] norm_y,
	input wire logic signed [acm_pkg::NORM_W-1:0] norm_z,
	input wire logic [1:0] region_kind,
	input wire logic [5:0][acm_pkg::POS_W-1:0] bounds,
	input wire logic depth_y,
	input wire logic cube,
	output logic valid_s1,
	output acm_pkg::ctrl_t ctrl_s1,
	output logic [2:0][acm_pkg::DIFF_W-1:0] ar_s1,
	output logic [2:0][acm_pkg::DIFF_W-1:0] rem_s1,
	output logic [2:0][UV_FRAC_BITS-1:0] quo_s1,
	output logic signed [acm_pkg::XY_W-1:0] x_s1,
	output logic signed [acm_pkg::XY_W-1:0] y_s1,
	output logic signed [acm_pkg::Z_W-1:0] z_s1
);
	localparam logic [acm_pkg::DIFF_W-1:0] TINY =
		acm_pkg::DIFF_W'((64'd1 << COORD_FRAC_BITS) / 64'd1000000);

	logic [2:0][acm_pkg::POS_W-1:0] pos_v;
	logic [2:0][acm_pkg::DIFF_W-1:0] an;
	logic [2:0][acm_pkg::DIFF_W-1:0] ar;
	acm_pkg::frac_mode_t mode [3];
	logic [16:0] anx, any_n, anz;
	logic signed [acm_pkg::Z_W-1:0] cx, cy;
	logic signed [acm_pkg::XY_W-1:0] sx, sy, px_r, py_r;
	logic signed [acm_pkg::Z_W-1:0] pz_r;
	logic signed [33:0] coord2, mid2;
	acm_pkg::ctrl_t ctrl;

	assign pos_v[0] = pos_x;
	assign pos_v[1] = pos_y;
	assign pos_v[2] = pos_z;

	// axis offset and range, classify the fraction
	for (genvar a = 0; a < 3; a++) begin : g_axis
		logic signed [acm_pkg::DIFF_W-1:0] r, n;
		assign r = $signed({bounds[2*a+1][31], bounds[2*a+1]})
			- $signed({bounds[2*a][31], bounds[2*a]});
		assign n = $signed({pos_v[a][31], pos_v[a]})
			- $signed({bounds[2*a][31], bounds[2*a]});
		assign ar[a] = r[32] ? 33'(-r) : 33'(r);
		assign an[a] = n[32] ? 33'(-n) : 33'(n);
		always_comb begin
			if (ar[a] <= TINY) begin
				mode[a] = acm_pkg::FR_HALF;
			end else if (n == '0 || n[32] != r[32]) begin
				mode[a] = acm_pkg::FR_ZERO;
			end else if (an[a] >= ar[a]) begin
				mode[a] = acm_pkg::FR_ONE;
			end else begin
				mode[a] = acm_pkg::FR_DIV;
			end
		end
	end

	// normal magnitudes for cap test
	assign anx = norm_x[15] ? 17'(-$signed({norm_x[15], norm_x})) : 17'({1'b0, norm_x});
	assign any_n = norm_y[15] ? 17'(-$signed({norm_y[15], norm_y})) : 17'({1'b0, norm_y});
	assign anz = norm_z[15] ? 17'(-$signed({norm_z[15], norm_z})) : 17'({1'b0, norm_z});

	// box-centred vector, scaled
	assign cx = (acm_pkg::Z_W'(pos_x) <<< 1) - acm_pkg::Z_W'($signed(bounds[0]))
		- acm_pkg::Z_W'($signed(bounds[1]));
	assign cy = (acm_pkg::Z_W'(pos_y) <<< 1) - acm_pkg::Z_W'($signed(bounds[2]))
		- acm_pkg::Z_W'($signed(bounds[3]));
	assign sx = acm_pkg::XY_W'(cx) <<< acm_pkg::VEC_SCALE;
	assign sy = acm_pkg::XY_W'(cy) <<< acm_pkg::VEC_SCALE;

	// quarter-turn pre-rotation into the right half plane
	always_comb begin
		px_r = sx;
		py_r = sy;
		pz_r = '0;
		if (sx[acm_pkg::XY_W-1]) begin
			if (!sy[acm_pkg::XY_W-1]) begin
				px_r = sy;
				py_r = -sx;
				pz_r = acm_pkg::TURN_QUARTER;
			end else begin
				px_r = -sy;
				py_r = sx;
				pz_r = -acm_pkg::TURN_QUARTER;
			end
		end
	end

	// which half of the box along the horizontal axis
	assign coord2 = depth_y ? (34'(pos_x) <<< 1) : (34'(pos_y) <<< 1);
	assign mid2 = depth_y ? 34'($signed(bounds[0])) + 34'($signed(bounds[1]))
		: 34'($signed(bounds[2])) + 34'($signed(bounds[3]));

	always_comb begin
		ctrl.cap = cube && (anz > anx) && (anz > any_n);
		ctrl.cube = cube;
		ctrl.upper = coord2 > mid2;
		ctrl.zero_vec = (cx == '0) && (cy == '0);
		ctrl.depth_y = depth_y;
		ctrl.nz_neg = norm_z[15];
		ctrl.region = region_kind;
		ctrl.mode_x = mode[0];
		ctrl.mode_y = mode[1];
		ctrl.mode_z = mode[2];
	end

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s1 <= ctrl;
			ar_s1 <= ar;
			rem_s1 <= an;
			quo_s1 <= '0;
			x_s1 <= px_r;
			y_s1 <= py_r;
			z_s1 <= pz_r;
		end
	end
endmodule
`default_nettype wire

// ===== src/acm_cell.sv =====
`default_nettype none
module acm_cell #(
	parameter int IDX = 0,
	parameter int UV_FRAC_BITS = acm_pkg::UV_FRAC_BITS_DEF,
	parameter int ANGLE_STAGES = acm_pkg::ANGLE_STAGES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic valid_in,
	input wire acm_pkg::ctrl_t ctrl_in,
	input wire logic [2:0][acm_pkg::DIFF_W-1:0] ar_in,
	input wire logic [2:0][acm_pkg::DIFF_W-1:0] rem_in,
	input wire logic [2:0][UV_FRAC_BITS-1:0] quo_in,
	input wire logic signed [acm_pkg::XY_W-1:0] x_in,
	input wire logic signed [acm_pkg::XY_W-1:0] y_in,
	input wire logic signed [acm_pkg::Z_W-1:0] z_in,
	output logic valid_s1,
	output acm_pkg::ctrl_t ctrl_s1,
	output logic [2:0][acm_pkg::DIFF_W-1:0] ar_s1,
	output logic [2:0][acm_pkg::DIFF_W-1:0] rem_s1,
	output logic [2:0][UV_FRAC_BITS-1:0] quo_s1,
	output logic signed [acm_pkg::XY_W-1:0] x_s1,
	output logic signed [acm_pkg::XY_W-1:0] y_s1,
	output logic signed [acm_pkg::Z_W-1:0] z_s1
);
	logic [2:0][acm_pkg::DIFF_W-1:0] rem_nx;
	logic [2:0][UV_FRAC_BITS-1:0] quo_nx;
	logic signed [acm_pkg::XY_W-1:0] x_nx, y_nx;
	logic signed [acm_pkg::Z_W-1:0] z_nx;

	// one quotient bit per axis
	for (genvar a = 0; a < 3; a++) begin : g_div
		if (IDX < UV_FRAC_BITS) begin : g_on
			logic [acm_pkg::DIFF_W:0] r2;
			logic ge;
			assign r2 = {rem_in[a], 1'b0};
			assign ge = r2 >= {1'b0, ar_in[a]};
			assign rem_nx[a] = ge ? acm_pkg::DIFF_W'(r2 - {1'b0, ar_in[a]})
				: r2[acm_pkg::DIFF_W-1:0];
			assign quo_nx[a] = {quo_in[a][UV_FRAC_BITS-2:0], ge};
		end else begin : g_off
			assign rem_nx[a] = rem_in[a];
			assign quo_nx[a] = quo_in[a];
		end
	end

	// one vectoring rotation
	if (IDX < ANGLE_STAGES) begin : g_rot
		localparam logic signed [acm_pkg::Z_W-1:0] ANG =
			acm_pkg::Z_W'(acm_pkg::ATAN_TURNS[IDX]);
		logic signed [acm_pkg::XY_W-1:0] dx, dy;
		assign dx = y_in >>> IDX;
		assign dy = x_in >>> IDX;
		always_comb begin
			if (!y_in[acm_pkg::XY_W-1]) begin
				x_nx = x_in + dx;
				y_nx = y_in - dy;
				z_nx = z_in + ANG;
			end else begin
				x_nx = x_in - dx;
				y_nx = y_in + dy;
				z_nx = z_in - ANG;
			end
		end
	end else begin : g_norot
		assign x_nx = x_in;
		assign y_nx = y_in;
		assign z_nx = z_in;
	end

	// hand over to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s1 <= ctrl_in;
			ar_s1 <= ar_in;
			rem_s1 <= rem_nx;
			quo_s1 <= quo_nx;
			x_s1 <= x_nx;
			y_s1 <= y_nx;
			z_s1 <= z_nx;
		end
	end
endmodule
`default_nettype wire

// ===== src/atlas_coordinate_mapper.sv =====
`default_nettype none
// channel   direction  handshake               payload
// in        request    in_valid / in_stall     pos_x..z, norm_x..z, region_kind
// out       result     out_valid / out_stall   tex_u, tex_v, cap_face, cube_side_face
// cfg       write      cfg_we                  cfg_index, cfg_data
//
// one request per cycle unless stalled; each passes the prep register, the
// cells (at most a quotient bit and a rotation each) and the output register
// the whole pipeline holds while a result sits stalled at the output
// arst_n clears all valid flags and configuration registers
module atlas_coordinate_mapper #(
	parameter int COORD_FRAC_BITS = acm_pkg::COORD_FRAC_BITS_DEF,
	parameter int UV_FRAC_BITS = acm_pkg::UV_FRAC_BITS_DEF,
	parameter int ANGLE_STAGES = acm_pkg::ANGLE_STAGES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [acm_pkg::POS_W-1:0] pos_x,
	input wire logic signed [acm_pkg::POS_W-1:0] pos_y,
	input wire logic signed [acm_pkg::POS_W-1:0] pos_z,
	input wire logic signed [acm_pkg::NORM_W-1:0] norm_x,
	input wire logic signed [acm_pkg::NORM_W-1:0] norm_y,
	input wire logic signed [acm_pkg::NORM_W-1:0] norm_z,
	input wire logic [1:0] region_kind,
	output logic out_valid,
	input wire logic out_stall,
	output logic [UV_FRAC_BITS:0] tex_u,
	output logic [UV_FRAC_BITS:0] tex_v,
	output logic cap_face,
	output logic cube_side_face,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	localparam int N = (UV_FRAC_BITS > ANGLE_STAGES) ? UV_FRAC_BITS : ANGLE_STAGES;
	localparam int W = UV_FRAC_BITS + 1;
	localparam int SH = 32 - UV_FRAC_BITS;
	localparam logic [W-1:0] ONE = W'(1) << UV_FRAC_BITS;
	localparam logic [33:0] RND = 34'd1 << (31 - UV_FRAC_BITS);

	logic [5:0][31:0] bound_q;
	logic depth_y_q, cube_q;
	logic en;

	logic [N:0] valid_c;
	acm_pkg::ctrl_t ctrl_c [N+1];
	logic [2:0][acm_pkg::DIFF_W-1:0] ar_c [N+1];
	logic [2:0][acm_pkg::DIFF_W-1:0] rem_c [N+1];
	logic [2:0][UV_FRAC_BITS-1:0] quo_c [N+1];
	logic signed [acm_pkg::XY_W-1:0] x_c [N+1];
	logic signed [acm_pkg::XY_W-1:0] y_c [N+1];
	logic signed [acm_pkg::Z_W-1:0] z_c [N+1];

	acm_pkg::ctrl_t cf;
	logic [W-1:0] fx, fy, fz, horiz, depth, u_nx, v_nx, cap_u;
	logic signed [acm_pkg::Z_W-1:0] zt;
	logic [33:0] zc, zr;
	logic [W-1:0] tex_u_q, tex_v_q;
	logic out_valid_q, cap_q, side_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q <= '0;
			depth_y_q <= 1'b0;
			cube_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				acm_pkg::REG_MIN_X: bound_q[0] <= cfg_data;
				acm_pkg::REG_MAX_X: bound_q[1] <= cfg_data;
				acm_pkg::REG_MIN_Y: bound_q[2] <= cfg_data;
				acm_pkg::REG_MAX_Y: bound_q[3] <= cfg_data;
				acm_pkg::REG_MIN_Z: bound_q[4] <= cfg_data;
				acm_pkg::REG_MAX_Z: bound_q[5] <= cfg_data;
				acm_pkg::REG_DEPTH_Y: depth_y_q <= cfg_data[0];
				acm_pkg::REG_CUBE: cube_q <= cfg_data[0];
			endcase
		end
	end

	// pipeline advance
	assign en = !(out_valid_q && out_stall);
	assign in_stall = !en;

	acm_prep #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS),
		.UV_FRAC_BITS(UV_FRAC_BITS)
	) u_prep (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
		.region_kind(region_kind), .bounds(bound_q),
		.depth_y(depth_y_q), .cube(cube_q),
		.valid_s1(valid_c[0]), .ctrl_s1(ctrl_c[0]), .ar_s1(ar_c[0]),
		.rem_s1(rem_c[0]), .quo_s1(quo_c[0]),
		.x_s1(x_c[0]), .y_s1(y_c[0]), .z_s1(z_c[0])
	);

	// chain of divide/rotate cells
	for (genvar k = 0; k < N; k++) begin : g_cell
		acm_cell #(
			.IDX(k),
			.UV_FRAC_BITS(UV_FRAC_BITS),
			.ANGLE_STAGES(ANGLE_STAGES)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_in(valid_c[k]), .ctrl_in(ctrl_c[k]), .ar_in(ar_c[k]),
			.rem_in(rem_c[k]), .quo_in(quo_c[k]),
			.x_in(x_c[k]), .y_in(y_c[k]), .z_in(z_c[k]),
			.valid_s1(valid_c[k+1]), .ctrl_s1(ctrl_c[k+1]), .ar_s1(ar_c[k+1]),
			.rem_s1(rem_c[k+1]), .quo_s1(quo_c[k+1]),
			.x_s1(x_c[k+1]), .y_s1(y_c[k+1]), .z_s1(z_c[k+1])
		);
	end

	assign cf = ctrl_c[N];

	// axis fractions from mode and quotient
	function automatic logic [W-1:0] frac_sel(input acm_pkg::frac_mode_t m,
		input logic [UV_FRAC_BITS-1:0] q);
		logic [W-1:0] f;
		unique case (m)
			acm_pkg::FR_HALF: f = ONE >> 1;
			acm_pkg::FR_ZERO: f = '0;
			acm_pkg::FR_ONE: f = ONE;
			acm_pkg::FR_DIV: f = {1'b0, q};
		endcase
		return f;
	endfunction

	assign fx = frac_sel(cf.mode_x, quo_c[N][0]);
	assign fy = frac_sel(cf.mode_y, quo_c[N][1]);
	assign fz = frac_sel(cf.mode_z, quo_c[N][2]);
	assign horiz = cf.depth_y ? fx : fy;
	assign depth = cf.depth_y ? fy : fx;

	// angle to u: add half turn, clamp, round
	assign zt = z_c[N] + acm_pkg::TURN_HALF;
	always_comb begin
		if (zt[acm_pkg::Z_W-1]) begin
			zc = '0;
		end else if (zt > acm_pkg::TURN_FULL) begin
			zc = 34'(acm_pkg::TURN_FULL);
		end else begin
			zc = zt[33:0];
		end
	end
	assign zr = (zc + RND) >> SH;
	assign cap_u = cf.zero_vec ? (ONE >> 1) : zr[W-1:0];

	// u and v selection
	always_comb begin
		if (cf.cap) begin
			u_nx = cap_u;
			v_nx = cf.nz_neg ? ONE : '0;
		end else begin
			v_nx = fz;
			unique case (cf.region)
				acm_pkg::REGION_SIDE: begin
					if (cf.upper) begin
						u_nx = (ONE >> 2) + (depth >> 2);
					end else begin
						u_nx = (ONE - (ONE >> 2)) + ((ONE - depth) >> 2);
					end
				end
				acm_pkg::REGION_BACK: u_nx = (ONE >> 1) + ((ONE - horiz) >> 2);
				default: u_nx = horiz >> 2;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_c[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tex_u_q <= u_nx;
			tex_v_q <= v_nx;
			cap_q <= cf.cap;
			side_q <= !cf.cap && cf.cube && (cf.region == acm_pkg::REGION_SIDE);
		end
	end

	assign out_valid = out_valid_q;
	assign tex_u = tex_u_q;
	assign tex_v = tex_v_q;
	assign cap_face = cap_q;
	assign cube_side_face = side_q;
endmodule
`default_nettype wire

// ===== src/acm_checker.sv =====
`default_nettype none
module acm_checker #(
	parameter int UV_FRAC_BITS = acm_pkg::UV_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [UV_FRAC_BITS:0] tex_u,
	input wire logic [UV_FRAC_BITS:0] tex_v,
	input wire logic cap_face,
	input wire logic cube_side_face
);
	localparam logic [UV_FRAC_BITS:0] ONE = (UV_FRAC_BITS+1)'(1) << UV_FRAC_BITS;

	// intake holds exactly while a result is stalled
	a_intake: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("intake stall mismatch");

	// stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tex_u) && $stable(tex_v))
		else $error("stalled result changed");

	// coordinates never exceed one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tex_u <= ONE && tex_v <= ONE)
		else $error("coordinate above one");

	// cap results: v at an edge, no side flag
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cap_face |-> !cube_side_face && (tex_v == '0 || tex_v == ONE))
		else $error("bad cap result");
endmodule

bind atlas_coordinate_mapper acm_checker #(.UV_FRAC_BITS(UV_FRAC_BITS)) u_acm_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .tex_u(tex_u), .tex_v(tex_v), .cap_face(cap_face),
	.cube_side_face(cube_side_face)
);
`default_nettype wire
